/* design/gtl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtl_pkg
// Shared types and constants of the grid tile layout block.
// ----------------------------------------------------------------------------
package gtl_pkg;

    localparam int COUNT_W = 7;
    localparam int AREA_W  = 14;
    localparam int POS_W   = 15;
    localparam int BORDER_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int DIVISOR_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_X       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_Y       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH = 3'd5;

    localparam logic MODE_GRID    = 1'b0;
    localparam logic MODE_MONOCLE = 1'b1;

    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic                layout_mode;
        logic [AREA_W-1:0]   area_x;
        logic [AREA_W-1:0]   area_y;
        logic [AREA_W-1:0]   area_width;
        logic [AREA_W-1:0]   area_height;
        logic [BORDER_W-1:0] border_width;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [AREA_W-1:0]    dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [AREA_W-1:0]    quotient;
        logic [DIVISOR_W-1:0] remainder;
    } div_rsp_t;

endpackage
`default_nettype wire

/* design/grid_tile_layout.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grid_tile_layout
// Places a number of windows on a screen area as a column grid or monocle.
//
// A request on the s_ channel carries a window count; the m_ channel then
// delivers one rectangle per window, in order, with m_last_window set on the
// final one. A count of zero produces no rectangles; counts above
// MAX_WINDOWS are treated as MAX_WINDOWS.
// The cfg_ port writes the layout registers; write only while idle.
// Monocle mode goes from the taken request straight to the output; grid
// mode first runs the root search and then four divisions (load, 14
// quotient steps, hand-off) on the shared divider.
// After that one rectangle leaves per cycle unless m_ready stalls the
// stream. Two requests can queue while one is being worked on.
// A stalled m_ready holds the current rectangle and pauses the stream.
// Reset empties the queue, drops any layout in flight and restores the
// register defaults (grid mode, 1920 x 1080 at the origin, border 1).
// ----------------------------------------------------------------------------
module grid_tile_layout #(
    parameter int MAX_WINDOWS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [13:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [6:0]  s_window_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_window_index,
    output logic [14:0]      m_pos_x,
    output logic [14:0]      m_pos_y,
    output logic [13:0]      m_rect_width,
    output logic [13:0]      m_rect_height,
    output logic             m_last_window
);
    import gtl_pkg::*;

    cfg_t   cfg_reg;
    logic   q_pop;
    logic   q_not_empty;
    count_t q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.layout_mode  <= MODE_GRID;
            cfg_reg.area_x       <= '0;
            cfg_reg.area_y       <= '0;
            cfg_reg.area_width   <= 14'd1920;
            cfg_reg.area_height  <= 14'd1080;
            cfg_reg.border_width <= 8'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LAYOUT_MODE:  cfg_reg.layout_mode  <= cfg_wdata[0];
                REG_AREA_X:       cfg_reg.area_x       <= cfg_wdata;
                REG_AREA_Y:       cfg_reg.area_y       <= cfg_wdata;
                REG_AREA_WIDTH:   cfg_reg.area_width   <= cfg_wdata;
                REG_AREA_HEIGHT:  cfg_reg.area_height  <= cfg_wdata;
                REG_BORDER_WIDTH: cfg_reg.border_width <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    gtl_front #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_window_count (s_window_count),
        .q_pop          (q_pop),
        .q_not_empty    (q_not_empty),
        .q_count        (q_count)
    );

    gtl_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_not_empty    (q_not_empty),
        .q_count        (q_count),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_window_index (m_window_index),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_rect_width   (m_rect_width),
        .m_rect_height  (m_rect_height),
        .m_last_window  (m_last_window)
    );

endmodule
`default_nettype wire

/* design/gtl_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtl_queue
// Two-entry queue of window counts between the front and the back.
// ----------------------------------------------------------------------------
module gtl_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire gtl_pkg::count_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output gtl_pkg::count_t      pop_data
);
    import gtl_pkg::*;

    count_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* design/gtl_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtl_front
// Takes layout requests, clamps the count and drops empty layouts.
// ----------------------------------------------------------------------------
module gtl_front #(
    parameter int MAX_WINDOWS = 64
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire gtl_pkg::count_t s_window_count,
    input  wire logic            q_pop,
    output logic                 q_not_empty,
    output gtl_pkg::count_t      q_count
);
    import gtl_pkg::*;

    localparam int CNT_MAX = (1 << COUNT_W) - 1;
    localparam int CAP = (MAX_WINDOWS > CNT_MAX) ? CNT_MAX : MAX_WINDOWS;

    logic   q_full;
    logic   push;
    count_t clamped;

    always_comb begin
        clamped = s_window_count;
        if ({1'b0, s_window_count} > (COUNT_W + 1)'(CAP)) begin
            clamped = COUNT_W'(CAP);
        end
    end

    assign s_ready = !q_full;
    // a zero count produces nothing, so it never reaches the back
    assign push    = s_valid && s_ready && (clamped != '0);

    gtl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (clamped),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_count)
    );

endmodule
`default_nettype wire

/* design/gtl_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtl_divider
// Restoring divider, one quotient bit per cycle, shared by the back end.
// ----------------------------------------------------------------------------
module gtl_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gtl_pkg::div_req_t req,
    output gtl_pkg::div_rsp_t      rsp
);
    import gtl_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'(AREA_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [3:0]           step_reg;
    logic [AREA_W-1:0]    quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[AREA_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[AREA_W-2:0], fits};
            if (fits) begin
                rem_reg <= DIVISOR_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_reg <= trial[DIVISOR_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

/* design/gtl_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtl_back
// Works out the grid for one request and streams out its rectangles.
// ----------------------------------------------------------------------------
module gtl_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire gtl_pkg::cfg_t   cfg,
    input  wire logic            q_not_empty,
    input  wire gtl_pkg::count_t q_count,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [5:0]           m_window_index,
    output logic [14:0]          m_pos_x,
    output logic [14:0]          m_pos_y,
    output logic [13:0]          m_rect_width,
    output logic [13:0]          m_rect_height,
    output logic                 m_last_window
);
    import gtl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROOT = 3'd1;
    localparam logic [2:0] S_ROWS = 3'd2;
    localparam logic [2:0] S_WID  = 3'd3;
    localparam logic [2:0] S_HM   = 3'd4;
    localparam logic [2:0] S_HO   = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]           state_reg;
    logic                 start_reg;
    logic                 mono_reg;
    count_t               n_reg;
    logic [3:0]           k_reg;
    logic [3:0]           cols_reg;
    count_t               other_rows_reg;
    count_t               main_rows_reg;
    logic [AREA_W-1:0]    w_avg_reg;
    logic [AREA_W-1:0]    w_main_reg;
    logic [AREA_W-1:0]    hm_q_reg;
    logic [DIVISOR_W-1:0] hm_r_reg;
    logic [AREA_W-1:0]    ho_q_reg;
    logic [DIVISOR_W-1:0] ho_r_reg;

    count_t               idx_reg;
    count_t               row_reg;
    logic                 in_main_reg;
    logic [POS_W-1:0]     x_reg;
    logic [POS_W-1:0]     y_reg;

    logic                 m_valid_reg;
    logic [5:0]           index_reg;
    logic [POS_W-1:0]     pos_x_reg;
    logic [POS_W-1:0]     pos_y_reg;
    logic [AREA_W-1:0]    width_reg;
    logic [AREA_W-1:0]    height_reg;
    logic                 last_reg;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic [4:0]           k_inc;
    logic [9:0]           k_sq;
    logic [8:0]           k_pron;
    logic [3:0]           cols_calc;
    logic [10:0]          full_rows;
    count_t               main_calc;
    logic [8:0]           border2;
    logic [AREA_W-1:0]    mono_w;
    logic [AREA_W-1:0]    mono_h;
    logic [AREA_W-1:0]    grid_w;
    logic [AREA_W-1:0]    grid_h;
    logic [AREA_W-1:0]    hq;
    logic [DIVISOR_W-1:0] hr;
    count_t               rc;
    logic                 col_end;
    logic                 is_last;
    logic                 load;

    gtl_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // integer root search, one candidate per cycle
    assign k_inc     = {1'b0, k_reg} + 5'd1;
    assign k_sq      = {5'b0, k_inc} * {5'b0, k_inc};
    assign k_pron    = {5'b0, k_reg} * {4'b0, k_inc};
    assign cols_calc = (k_pron <= {2'b0, n_reg}) ? k_reg + 4'd1 : k_reg;

    // first column takes what the full columns leave
    assign full_rows = {7'b0, cols_reg - 4'd1} * {4'b0, div_rsp.quotient[DIVISOR_W-1:0]};
    assign main_calc = (full_rows < {4'b0, n_reg}) ?
                       COUNT_W'({4'b0, n_reg} - full_rows) : COUNT_W'(1);

    always_comb begin
        div_req.start    = start_reg;
        div_req.dividend = cfg.area_height;
        div_req.divisor  = main_rows_reg;
        unique case (state_reg)
            S_ROWS: begin
                div_req.dividend = AREA_W'({1'b0, n_reg} + {4'b0, cols_reg} - 8'd1);
                div_req.divisor  = {3'b0, cols_reg};
            end
            S_WID: begin
                div_req.dividend = cfg.area_width;
                div_req.divisor  = {3'b0, cols_reg};
            end
            S_HO: begin
                div_req.divisor  = other_rows_reg;
            end
            default: begin
            end
        endcase
    end

    assign border2 = {cfg.border_width, 1'b0};
    assign mono_w  = (cfg.area_width > {5'b0, border2}) ?
                     cfg.area_width - {5'b0, border2} : '0;
    assign mono_h  = (cfg.area_height > {5'b0, border2}) ?
                     cfg.area_height - {5'b0, border2} : '0;

    assign rc      = in_main_reg ? main_rows_reg : other_rows_reg;
    assign hq      = in_main_reg ? hm_q_reg : ho_q_reg;
    assign hr      = in_main_reg ? hm_r_reg : ho_r_reg;
    // row zero absorbs the height remainder
    assign grid_h  = (row_reg == '0) ? hq + {7'b0, hr} : hq;
    assign grid_w  = in_main_reg ? w_main_reg : w_avg_reg;
    assign col_end = ({1'b0, row_reg} + 8'd1) == {1'b0, rc};
    assign is_last = (idx_reg == n_reg - COUNT_W'(1));

    assign load    = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);
    assign q_pop   = (state_reg == S_IDLE) && q_not_empty;

    assign m_valid        = m_valid_reg;
    assign m_window_index = index_reg;
    assign m_pos_x        = pos_x_reg;
    assign m_pos_y        = pos_y_reg;
    assign m_rect_width   = width_reg;
    assign m_rect_height  = height_reg;
    assign m_last_window  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_not_empty) begin
                        state_reg <= (cfg.layout_mode == MODE_MONOCLE) ? S_EMIT : S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (k_sq > {3'b0, n_reg}) begin
                        state_reg <= S_ROWS;
                        start_reg <= 1'b1;
                    end
                end
                S_ROWS: begin
                    if (div_rsp.done) begin
                        state_reg <= S_WID;
                        start_reg <= 1'b1;
                    end
                end
                S_WID: begin
                    if (div_rsp.done) begin
                        state_reg <= S_HM;
                        start_reg <= 1'b1;
                    end
                end
                S_HM: begin
                    if (div_rsp.done) begin
                        state_reg <= S_HO;
                        start_reg <= 1'b1;
                    end
                end
                S_HO: begin
                    if (div_rsp.done) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (load && is_last) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            n_reg       <= q_count;
            mono_reg    <= cfg.layout_mode;
            k_reg       <= '0;
            idx_reg     <= '0;
            row_reg     <= '0;
            in_main_reg <= 1'b1;
            x_reg       <= {1'b0, cfg.area_x};
            y_reg       <= {1'b0, cfg.area_y};
        end
        if (state_reg == S_ROOT) begin
            if (k_sq <= {3'b0, n_reg}) begin
                k_reg <= k_inc[3:0];
            end else begin
                cols_reg <= cols_calc;
            end
        end
        if (div_rsp.done) begin
            unique case (state_reg)
                S_ROWS: begin
                    other_rows_reg <= div_rsp.quotient[DIVISOR_W-1:0];
                    main_rows_reg  <= main_calc;
                end
                S_WID: begin
                    w_avg_reg  <= div_rsp.quotient;
                    w_main_reg <= div_rsp.quotient + {7'b0, div_rsp.remainder};
                end
                S_HM: begin
                    hm_q_reg <= div_rsp.quotient;
                    hm_r_reg <= div_rsp.remainder;
                end
                S_HO: begin
                    ho_q_reg <= div_rsp.quotient;
                    ho_r_reg <= div_rsp.remainder;
                end
                default: begin
                end
            endcase
        end
        if (load) begin
            index_reg <= idx_reg[5:0];
            last_reg  <= is_last;
            idx_reg   <= idx_reg + COUNT_W'(1);
            if (mono_reg) begin
                pos_x_reg  <= {1'b0, cfg.area_x};
                pos_y_reg  <= {1'b0, cfg.area_y};
                width_reg  <= mono_w;
                height_reg <= mono_h;
            end else begin
                pos_x_reg  <= x_reg;
                pos_y_reg  <= y_reg;
                width_reg  <= grid_w;
                height_reg <= grid_h;
                // next column starts at the top, one column width to the right
                if (col_end) begin
                    row_reg     <= '0;
                    in_main_reg <= 1'b0;
                    x_reg       <= x_reg + {1'b0, grid_w};
                    y_reg       <= {1'b0, cfg.area_y};
                end else begin
                    row_reg <= row_reg + COUNT_W'(1);
                    y_reg   <= y_reg + {1'b0, grid_h};
                end
            end
        end
    end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid tile layout block.
//
// A table of directed requests covers the reset setup, field extremes, both
// layout modes, the count clamp and the border saturation. Random phases
// follow, each with a fresh register setup written while the block is idle.
// Every accepted request is expanded by a local model of the layout rules
// into the rectangles it should produce; each returned rectangle is checked
// field by field against the oldest one still owed. The sender works in
// bursts and the receiver stalls on patterns of its own, with one long
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    import gtl_pkg::*;

    localparam int  MAX_WINDOWS   = 64;
    localparam int  ITEM_TARGET   = 480;
    localparam int  SETTLE_CYCLES = 300;
    localparam int  HOLD_CYCLES   = 600;
    localparam real LIMIT_NS      = 15_000_000.0;

    typedef struct packed {
        logic [5:0]        index;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [AREA_W-1:0] width;
        logic [AREA_W-1:0] height;
        logic              last;
    } window_rect_t;

    typedef struct packed {
        logic                mode;
        logic [AREA_W-1:0]   ax;
        logic [AREA_W-1:0]   ay;
        logic [AREA_W-1:0]   aw;
        logic [AREA_W-1:0]   ah;
        logic [BORDER_W-1:0] bw;
        count_t              cnt;
        logic                typed;
        logic [POS_W-1:0]    ex_x;
        logic [POS_W-1:0]    ex_y;
        logic [AREA_W-1:0]   ex_w;
        logic [AREA_W-1:0]   ex_h;
    } layout_row_t;

    // typed rows are single-window layouts whose rectangle is plain to see
    layout_row_t layout_rows [20] = '{
        '{MODE_GRID,    0,     0,     1920,  1080,  1,   1,   1, 0, 0, 1920, 1080},
        '{MODE_GRID,    0,     0,     1920,  1080,  1,   0,   0, 0, 0, 0, 0},
        '{MODE_GRID,    0,     0,     1920,  1080,  1,   2,   0, 0, 0, 0, 0},
        '{MODE_GRID,    0,     0,     1920,  1080,  1,   3,   0, 0, 0, 0, 0},
        '{MODE_GRID,    0,     0,     1920,  1080,  1,   5,   0, 0, 0, 0, 0},
        '{MODE_GRID,    0,     0,     1920,  1080,  1,   7,   0, 0, 0, 0, 0},
        '{MODE_GRID,    0,     0,     1920,  1080,  1,   12,  0, 0, 0, 0, 0},
        '{MODE_GRID,    0,     0,     1920,  1080,  1,   64,  0, 0, 0, 0, 0},
        '{MODE_GRID,    0,     0,     1920,  1080,  1,   127, 0, 0, 0, 0, 0},
        '{MODE_GRID,    0,     0,     1920,  1080,  1,   65,  0, 0, 0, 0, 0},
        '{MODE_GRID,    16383, 16383, 16383, 16383, 255, 64,  0, 0, 0, 0, 0},
        '{MODE_GRID,    16383, 16383, 16383, 16383, 255, 1,
          1, 16383, 16383, 16383, 16383},
        '{MODE_GRID,    0,     0,     0,     0,     0,   9,   0, 0, 0, 0, 0},
        '{MODE_MONOCLE, 16383, 16383, 16383, 16383, 0,   1,
          1, 16383, 16383, 16383, 16383},
        '{MODE_MONOCLE, 100,   200,   510,   509,   255, 1,   1, 100, 200, 0, 0},
        '{MODE_MONOCLE, 100,   200,   511,   16383, 255, 4,   0, 0, 0, 0, 0},
        '{MODE_MONOCLE, 5,     6,     1920,  1080,  1,   64,  0, 0, 0, 0, 0},
        '{MODE_MONOCLE, 5,     6,     1920,  1080,  1,   0,   0, 0, 0, 0, 0},
        '{MODE_GRID,    7,     9,     1000,  3,     0,   10,  0, 0, 0, 0, 0},
        '{MODE_GRID,    0,     0,     1,     1,     0,   2,   0, 0, 0, 0, 0}
    };

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [2:0]        cfg_index;
    logic [13:0]       cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic [6:0]        s_window_count;
    logic              m_valid;
    logic              m_ready;
    logic [5:0]        m_window_index;
    logic [14:0]       m_pos_x;
    logic [14:0]       m_pos_y;
    logic [13:0]       m_rect_width;
    logic [13:0]       m_rect_height;
    logic              m_last_window;

    cfg_t              layout_cfg;
    window_rect_t      owed_rects [$];
    int                mismatch_count;
    int                requests_taken;
    int                burst_left;
    bit                gaps_on;
    bit                hold_off_request;

    grid_tile_layout #(
        .MAX_WINDOWS(MAX_WINDOWS)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_window_count (s_window_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_window_index (m_window_index),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_rect_width   (m_rect_width),
        .m_rect_height  (m_rect_height),
        .m_last_window  (m_last_window)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    // expands one window count into the rectangles the block owes
    function automatic void place_windows(input count_t cnt);
        int unsigned  n, cols, other_rows, main_rows, w_avg, w_main;
        int unsigned  x, y, row, rc, w, h_avg, h, j, dbl, sw, sh;
        window_rect_t r;

        n = cnt;
        if (n > MAX_WINDOWS) n = MAX_WINDOWS;
        if (n == 0) return;

        if (layout_cfg.layout_mode == MODE_MONOCLE) begin
            dbl = 2 * layout_cfg.border_width;
            sw  = (layout_cfg.area_width > dbl) ? layout_cfg.area_width - dbl : 0;
            sh  = (layout_cfg.area_height > dbl) ? layout_cfg.area_height - dbl : 0;
            for (int unsigned i = 0; i < n; i++) begin
                r.index  = i[5:0];
                r.pos_x  = POS_W'(layout_cfg.area_x);
                r.pos_y  = POS_W'(layout_cfg.area_y);
                r.width  = sw[AREA_W-1:0];
                r.height = sh[AREA_W-1:0];
                r.last   = (i == n - 1);
                owed_rects.push_back(r);
            end
            return;
        end

        cols = 0;
        while ((cols + 1) * (cols + 1) <= n) cols++;
        if (cols * (cols + 1) <= n) cols++;
        other_rows = (n + cols - 1) / cols;
        main_rows  = ((cols - 1) * other_rows < n) ? n - (cols - 1) * other_rows : 1;
        w_avg      = layout_cfg.area_width / cols;
        w_main     = layout_cfg.area_width - (cols - 1) * w_avg;
        x          = layout_cfg.area_x;
        y          = layout_cfg.area_y;

        for (int unsigned i = 0; i < n; i++) begin
            if (i < main_rows) begin
                row = i;
                rc  = main_rows;
                w   = w_main;
            end else begin
                j   = i - main_rows;
                rc  = other_rows;
                w   = w_avg;
                row = j % rc;
                // a new column starts: step right and back to the top
                if (row == 0) begin
                    x += (j == 0) ? w_main : w_avg;
                    y  = layout_cfg.area_y;
                end
            end
            h_avg = layout_cfg.area_height / rc;
            h     = (row == 0) ? layout_cfg.area_height - h_avg * (rc - 1) : h_avg;
            r.index  = i[5:0];
            r.pos_x  = x[POS_W-1:0];
            r.pos_y  = y[POS_W-1:0];
            r.width  = w[AREA_W-1:0];
            r.height = h[AREA_W-1:0];
            r.last   = (i == n - 1);
            owed_rects.push_back(r);
            y += h;
        end
    endfunction

    function automatic logic [AREA_W-1:0] pick_area_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return AREA_W'($urandom_range(0, 16383));
            default: return AREA_W'($urandom_range(100, 4000));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [13:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic set_layout(input cfg_t nc);
        write_reg(REG_LAYOUT_MODE,  14'(nc.layout_mode));
        write_reg(REG_AREA_X,       nc.area_x);
        write_reg(REG_AREA_Y,       nc.area_y);
        write_reg(REG_AREA_WIDTH,   nc.area_width);
        write_reg(REG_AREA_HEIGHT,  nc.area_height);
        write_reg(REG_BORDER_WIDTH, 14'(nc.border_width));
        cfg_wr_en  <= 1'b0;
        layout_cfg  = nc;
    endtask

    // zero-count requests leave nothing owed, as the front drops them
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (owed_rects.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic offer_request(input count_t cnt, input bit use_typed,
                                 input window_rect_t typed_rect);
        int gap;
        s_valid        <= 1'b1;
        s_window_count <= cnt;
        do @(posedge aclk); while (!s_ready);
        if (use_typed) owed_rects.push_back(typed_rect);
        else place_windows(cnt);
        requests_taken++;
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 7);
                gap        = $urandom_range(1, 25);
                s_valid   <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic count_t pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 13) return count_t'($urandom_range(65, 127));
        if (r < 25) return count_t'($urandom_range(1, 4));
        return count_t'($urandom_range(1, 64));
    endfunction

    // receiver: a stall pattern that changes now and then, plus one long hold-off
    initial begin
        int pattern;
        int pattern_left;
        int hold_left;
        m_ready      = 1'b0;
        pattern      = 0;
        pattern_left = 0;
        hold_left    = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left        = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = $urandom_range(0, 3);
                    pattern_left = $urandom_range(20, 300);
                end
                pattern_left--;
                case (pattern)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 2) == 0);
                    default: m_ready <= (pattern_left % 4) != 0;
                endcase
            end
        end
    end

    always @(posedge aclk) begin : rect_check
        window_rect_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_rects.size() == 0) begin
                $error("unexpected rectangle, window_index %0d", m_window_index);
                mismatch_count++;
            end else begin
                want = owed_rects.pop_front();
                if (m_window_index !== want.index) begin
                    $error("window_index: expected %0d, got %0d", want.index, m_window_index);
                    mismatch_count++;
                end
                if (m_pos_x !== want.pos_x) begin
                    $error("pos_x: expected %0d, got %0d", want.pos_x, m_pos_x);
                    mismatch_count++;
                end
                if (m_pos_y !== want.pos_y) begin
                    $error("pos_y: expected %0d, got %0d", want.pos_y, m_pos_y);
                    mismatch_count++;
                end
                if (m_rect_width !== want.width) begin
                    $error("rect_width: expected %0d, got %0d", want.width, m_rect_width);
                    mismatch_count++;
                end
                if (m_rect_height !== want.height) begin
                    $error("rect_height: expected %0d, got %0d", want.height, m_rect_height);
                    mismatch_count++;
                end
                if (m_last_window !== want.last) begin
                    $error("last_window: expected %0d, got %0d", want.last, m_last_window);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        cfg_t         nc;
        window_rect_t typed_rect;
        int           phase;
        int           burst;

        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_window_count   = '0;
        mismatch_count   = 0;
        requests_taken   = 0;
        burst_left       = 0;
        gaps_on          = 1'b1;
        hold_off_request = 1'b0;
        layout_cfg       = '{MODE_GRID, 14'd0, 14'd0, 14'd1920, 14'd1080, 8'd1};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (layout_rows[k]) begin
            nc = '{layout_rows[k].mode, layout_rows[k].ax, layout_rows[k].ay,
                   layout_rows[k].aw, layout_rows[k].ah, layout_rows[k].bw};
            if (nc != layout_cfg) begin
                wait_idle();
                set_layout(nc);
            end
            typed_rect = '{6'd0, layout_rows[k].ex_x, layout_rows[k].ex_y,
                           layout_rows[k].ex_w, layout_rows[k].ex_h, 1'b1};
            offer_request(layout_rows[k].cnt, layout_rows[k].typed, typed_rect);
        end

        phase = 0;
        while (requests_taken < ITEM_TARGET) begin
            wait_idle();
            nc.layout_mode  = ($urandom_range(0, 2) == 0) ? MODE_MONOCLE : MODE_GRID;
            nc.area_x       = pick_area_value();
            nc.area_y       = pick_area_value();
            nc.area_width   = pick_area_value();
            nc.area_height  = pick_area_value();
            nc.border_width = BORDER_W'($urandom_range(0, 255));
            set_layout(nc);
            if (phase == 2) begin
                // back up the block: receiver holds off, sender keeps offering
                gaps_on          = 1'b0;
                hold_off_request = 1'b1;
                repeat (8) offer_request(count_t'($urandom_range(1, 64)), 1'b0, '0);
            end else begin
                gaps_on = ($urandom_range(0, 3) != 0);
                burst   = $urandom_range(10, 40);
                repeat (burst) offer_request(pick_count(), 1'b0, '0);
            end
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0 && owed_rects.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
